/* src/radix2_complex_fft_top_macros.svh */
// assertion macros for the radix-2 fft block
// users need clk_i and rst_ni in scope
`ifndef RADIX2_COMPLEX_FFT_TOP_MACROS_SVH
`define RADIX2_COMPLEX_FFT_TOP_MACROS_SVH

// same-cycle implication
`define R2F_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define R2F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/r2fft_pkg.sv */
// shared types, constants and twiddle rom for the radix-2 fft block
// no dependencies
package r2fft_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int DATA_W       = 22;
  localparam int BIN_W        = 6;
  localparam int LOG2_W       = 3;
  localparam int TW_IDX_W     = 5;
  localparam int ROM_LOG2_PTS = 6;
  localparam int ROM_FRAC     = 23;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int LOG2_RESET   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_SIZE    = 4'd0,
    CFG_INVERSE_MODE = 4'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WSEL_SAMPLE  = 3'd0,
    WSEL_RD_A    = 3'd1,
    WSEL_RD_B    = 3'd2,
    WSEL_SUM_TOP = 3'd3,
    WSEL_SUM_BOT = 3'd4
  } wsel_e;

  typedef struct packed {
    logic              wr_en;
    wsel_e             wsel;
    logic              rd_en;
    logic              out_load;
    logic              inverse;
    logic [LOG2_W-1:0] log2_size;
  } dp_cmd_t;

  // sin(k*pi/32) in q1.23, k = 0..16
  localparam int QUARTER_ROM [17] = '{
    0, 822227, 1636536, 2435084, 3210181, 3954362, 4660461, 5321677,
    5931642, 6484482, 6974873, 7398092, 7750063, 8027397, 8227423, 8348215,
    8388608
  };

  function automatic int rom_value(int k, int tw);
    int sh;
    int lim;
    int v;
    sh  = ROM_FRAC + 1 - tw;
    lim = (1 << (tw - 1)) - 1;
    if (sh == 0) begin
      v = QUARTER_ROM[k];
    end else begin
      v = (QUARTER_ROM[k] + (1 << (sh - 1))) >>> sh;
    end
    if (v > lim) begin
      v = lim;
    end
    return v;
  endfunction

  // cos(2*pi*e/64)
  function automatic int tw_cos(logic [TW_IDX_W-1:0] e, int tw);
    int ei;
    ei = int'(e);
    if (ei <= 16) begin
      return rom_value(16 - ei, tw);
    end
    return -rom_value(ei - 16, tw);
  endfunction

  // sin(2*pi*e/64)
  function automatic int tw_sin(logic [TW_IDX_W-1:0] e, int tw);
    int ei;
    ei = int'(e);
    if (ei <= 16) begin
      return rom_value(ei, tw);
    end
    return rom_value(32 - ei, tw);
  endfunction

endpackage

/* src/r2fft_dp.sv */
// datapath: frame buffer, butterfly arithmetic, output scaling
// depends on r2fft_pkg
module r2fft_dp #(
  parameter int AW = 6,
  parameter int TW = 16
) (
  input  logic                                  clk_i,
  input  r2fft_pkg::dp_cmd_t                    cmd_i,
  input  logic [AW-1:0]                         waddr_i,
  input  logic [AW-1:0]                         raddr_a_i,
  input  logic [AW-1:0]                         raddr_b_i,
  input  logic [r2fft_pkg::TW_IDX_W-1:0]        tw_idx_i,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im_i,
  output logic signed [r2fft_pkg::DATA_W-1:0]   out_re_o,
  output logic signed [r2fft_pkg::DATA_W-1:0]   out_im_o
);

  localparam int DW    = r2fft_pkg::DATA_W;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = DW + TW;
  localparam int SW    = PW + 2;
  localparam int TRW   = SW - (TW - 1);
  localparam int SUMW  = TRW + 1;
  localparam logic signed [SW-1:0]   HALF    = SW'(1) << (TW - 2);
  localparam logic signed [SUMW-1:0] SAT_MAX = SUMW'((2 ** (DW - 1)) - 1);
  localparam logic signed [SUMW-1:0] SAT_MIN = -SUMW'(2 ** (DW - 1));

  logic [2*DW-1:0] mem_q [DEPTH];
  logic [2*DW-1:0] rd_a_q, rd_b_q, wdata;

  logic signed [DW-1:0] a_re, a_im, b_re, b_im;
  logic signed [TW-1:0] w_re, w_sn, w_im;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [SW-1:0] tr_sum, ti_sum, tr_sh, ti_sh;
  logic signed [TRW-1:0] t_re_q, t_im_q;
  logic signed [DW-1:0] top_re_q, top_im_q, bot_re_q, bot_im_q;
  logic signed [DW:0]   rnd, sc_re, sc_im;

  function automatic logic signed [DW-1:0] sat(input logic signed [SUMW-1:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[DW-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  assign a_re = rd_a_q[2*DW-1:DW];
  assign a_im = rd_a_q[DW-1:0];
  assign b_re = rd_b_q[2*DW-1:DW];
  assign b_im = rd_b_q[DW-1:0];

  assign w_re = TW'(r2fft_pkg::tw_cos(tw_idx_i, TW));
  assign w_sn = TW'(r2fft_pkg::tw_sin(tw_idx_i, TW));
  assign w_im = cmd_i.inverse ? w_sn : -w_sn;

  always_comb begin
    unique case (cmd_i.wsel)
      r2fft_pkg::WSEL_SAMPLE:  wdata = {DW'(sample_re_i), DW'(sample_im_i)};
      r2fft_pkg::WSEL_RD_A:    wdata = rd_a_q;
      r2fft_pkg::WSEL_RD_B:    wdata = rd_b_q;
      r2fft_pkg::WSEL_SUM_TOP: wdata = {top_re_q, top_im_q};
      r2fft_pkg::WSEL_SUM_BOT: wdata = {bot_re_q, bot_im_q};
      default:                 wdata = rd_a_q;
    endcase
  end

  // frame buffer, two registered read ports, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  // twiddle product with round half up
  assign tr_sum = SW'(p_rr_q) - SW'(p_ii_q) + HALF;
  assign ti_sum = SW'(p_ri_q) + SW'(p_ir_q) + HALF;
  assign tr_sh  = tr_sum >>> (TW - 1);
  assign ti_sh  = ti_sum >>> (TW - 1);

  always_ff @(posedge clk_i) begin
    p_rr_q   <= w_re * b_re;
    p_ii_q   <= w_im * b_im;
    p_ri_q   <= w_re * b_im;
    p_ir_q   <= w_im * b_re;
    t_re_q   <= tr_sh[TRW-1:0];
    t_im_q   <= ti_sh[TRW-1:0];
    top_re_q <= sat(SUMW'(a_re) + SUMW'(t_re_q));
    top_im_q <= sat(SUMW'(a_im) + SUMW'(t_im_q));
    bot_re_q <= sat(SUMW'(a_re) - SUMW'(t_re_q));
    bot_im_q <= sat(SUMW'(a_im) - SUMW'(t_im_q));
  end

  // inverse scaling by rounding arithmetic shift
  assign rnd   = (DW + 1)'(1) << (cmd_i.log2_size - 1'b1);
  assign sc_re = ((DW + 1)'(a_re) + rnd) >>> cmd_i.log2_size;
  assign sc_im = ((DW + 1)'(a_im) + rnd) >>> cmd_i.log2_size;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_o <= cmd_i.inverse ? sc_re[DW-1:0] : a_re;
      out_im_o <= cmd_i.inverse ? sc_im[DW-1:0] : a_im;
    end
  end

endmodule

/* src/r2fft_ctrl.sv */
// controller: config registers, load/permute/butterfly/output sequencing
// depends on r2fft_pkg and radix2_complex_fft_top_macros.svh
`include "radix2_complex_fft_top_macros.svh"
module r2fft_ctrl #(
  parameter int AW = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                  cfg_ready_o,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [r2fft_pkg::BIN_W-1:0]           bin_index_o,
  output logic                                  last_bin_o,
  output r2fft_pkg::dp_cmd_t                    cmd_o,
  output logic [AW-1:0]                         waddr_o,
  output logic [AW-1:0]                         raddr_a_o,
  output logic [AW-1:0]                         raddr_b_o,
  output logic [r2fft_pkg::TW_IDX_W-1:0]        tw_idx_o
);

  localparam int LW = r2fft_pkg::LOG2_W;

  typedef enum logic [12:0] {
    S_LOAD   = 13'b0000000000001,
    S_P_RD   = 13'b0000000000010,
    S_P_W1   = 13'b0000000000100,
    S_P_W2   = 13'b0000000001000,
    S_B_RD   = 13'b0000000010000,
    S_B_MUL  = 13'b0000000100000,
    S_B_TW   = 13'b0000001000000,
    S_B_SUM  = 13'b0000010000000,
    S_B_WA   = 13'b0000100000000,
    S_B_WB   = 13'b0001000000000,
    S_O_RD   = 13'b0010000000000,
    S_O_LD   = 13'b0100000000000,
    S_O_HOLD = 13'b1000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] log2_q;
  logic          inv_q;
  logic [AW-1:0] load_q, load_d, idx_q, idx_d;
  logic [LW-1:0] stage_q, stage_d;

  logic [LW-1:0] lg_eff;
  logic [AW:0]   n_full, h_full;
  logic [AW-1:0] last_idx, half_last, lo_mask, lo, top, bot, rev_idx;
  logic [r2fft_pkg::ROM_LOG2_PTS-1:0] e_full;
  logic          accept, frame_done;

  function automatic logic [AW-1:0] rev(logic [AW-1:0] v, logic [LW-1:0] lg);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) begin
      r[i] = v[AW-1-i];
    end
    return r >> (AW - int'(lg));
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= LW'(r2fft_pkg::LOG2_RESET);
      inv_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == r2fft_pkg::CFG_LOG2_SIZE) begin
        log2_q <= cfg_data_i[LW-1:0];
      end else if (cfg_index_i == r2fft_pkg::CFG_INVERSE_MODE) begin
        inv_q <= cfg_data_i[0];
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (log2_q == '0) begin
      lg_eff = LW'(1);
    end else if (int'(log2_q) > AW) begin
      lg_eff = LW'(AW);
    end else begin
      lg_eff = log2_q;
    end
  end

  assign n_full    = (AW + 1)'(1) << lg_eff;
  assign last_idx  = AW'(n_full - 1'b1);
  assign half_last = AW'((n_full >> 1) - 1'b1);

  // butterfly addressing: insert a zero at bit stage-1 of the counter
  assign h_full  = (AW + 1)'(1) << (stage_q - 1'b1);
  assign lo_mask = AW'(h_full - 1'b1);
  assign lo      = idx_q & lo_mask;
  assign top     = AW'({idx_q & ~lo_mask, 1'b0}) | lo;
  assign bot     = top | AW'(h_full);
  assign e_full  = r2fft_pkg::ROM_LOG2_PTS'(lo)
                   << (LW'(r2fft_pkg::ROM_LOG2_PTS) - stage_q);
  assign tw_idx_o = e_full[r2fft_pkg::TW_IDX_W-1:0];
  assign rev_idx  = rev(idx_q, lg_eff);

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_O_HOLD);
  assign bin_index_o = r2fft_pkg::BIN_W'(idx_q);
  assign last_bin_o  = (idx_q == last_idx);
  assign accept      = in_valid_i && (state_q == S_LOAD);
  assign frame_done  = accept && (((AW + 1)'(load_q) + 1'b1) >= n_full);

  always_comb begin
    state_d        = state_q;
    load_d         = load_q;
    idx_d          = idx_q;
    stage_d        = stage_q;
    cmd_o          = '0;
    cmd_o.wsel     = r2fft_pkg::WSEL_SAMPLE;
    cmd_o.inverse  = inv_q;
    cmd_o.log2_size = lg_eff;
    waddr_o        = load_q;
    raddr_a_o      = idx_q;
    raddr_b_o      = rev_idx;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          cmd_o.wr_en = 1'b1;
          if (frame_done) begin
            load_d  = '0;
            idx_d   = '0;
            state_d = S_P_RD;
          end else begin
            load_d = load_q + 1'b1;
          end
        end
      end
      S_P_RD: begin
        if (rev_idx > idx_q) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_P_W1;
        end else if (idx_q == last_idx) begin
          idx_d   = '0;
          stage_d = LW'(1);
          state_d = S_B_RD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_P_W1: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = r2fft_pkg::WSEL_RD_B;
        waddr_o     = idx_q;
        state_d     = S_P_W2;
      end
      S_P_W2: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = r2fft_pkg::WSEL_RD_A;
        waddr_o     = rev_idx;
        if (idx_q == last_idx) begin
          idx_d   = '0;
          stage_d = LW'(1);
          state_d = S_B_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_P_RD;
        end
      end
      S_B_RD: begin
        cmd_o.rd_en = 1'b1;
        raddr_a_o   = top;
        raddr_b_o   = bot;
        state_d     = S_B_MUL;
      end
      S_B_MUL: state_d = S_B_TW;
      S_B_TW:  state_d = S_B_SUM;
      S_B_SUM: state_d = S_B_WA;
      S_B_WA: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = r2fft_pkg::WSEL_SUM_TOP;
        waddr_o     = top;
        state_d     = S_B_WB;
      end
      S_B_WB: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = r2fft_pkg::WSEL_SUM_BOT;
        waddr_o     = bot;
        if (idx_q == half_last) begin
          idx_d = '0;
          if (stage_q == lg_eff) begin
            state_d = S_O_RD;
          end else begin
            stage_d = stage_q + 1'b1;
            state_d = S_B_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_B_RD;
        end
      end
      S_O_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_O_LD;
      end
      S_O_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_O_HOLD;
      end
      S_O_HOLD: begin
        if (!out_stall_i) begin
          if (idx_q == last_idx) begin
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_O_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      load_q  <= '0;
      idx_q   <= '0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      idx_q   <= idx_d;
      stage_q <= stage_d;
    end
  end

  `R2F_ASSERT_NOW(a_no_load_while_emit, out_valid_o, in_stall_o, "input open while emitting")
  `R2F_ASSERT_NEXT(a_frame_starts_perm, frame_done, state_q == S_P_RD, "frame end missed")
  `R2F_ASSERT_NEXT(a_last_returns_load, out_valid_o && last_bin_o && !out_stall_i, !in_stall_o && !out_valid_o, "no return to load")
  `R2F_ASSERT_NOW(a_bfly_pair_order, state_q == S_B_RD, bot > top, "butterfly pair misordered")

endmodule

/* src/radix2_complex_fft_top.sv */
// top level of the radix-2 decimation-in-time fft
// depends on r2fft_pkg, r2fft_ctrl, r2fft_dp
//
// channel  direction  handshake                    payload
// in       sink       in_valid_i / in_stall_o      sample_re_i, sample_im_i
// out      source     out_valid_o / out_stall_i    out_re_o, out_im_o, bin_index_o, last_bin_o
// cfg      sink       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// loading takes one cycle per sample; the frame's last sample starts the transform
// bit-reversal pass: every index is checked; a pair to swap is read, then written back crosswise
// butterflies: (n/2)*log2(n), one at a time; the one write port takes top, then bottom
// output: each bin is read, registered and held while out_stall_i is high
// reset clears control and config (size 64, forward); the buffer needs no clearing pass
module radix2_complex_fft_top #(
  parameter int MAX_LOG2_SIZE = 6,
  parameter int TWIDDLE_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [r2fft_pkg::DATA_W-1:0]   out_re_o,
  output logic signed [r2fft_pkg::DATA_W-1:0]   out_im_o,
  output logic [r2fft_pkg::BIN_W-1:0]           bin_index_o,
  output logic                                  last_bin_o
);

  // controller to datapath command bundle and buffer addresses
  r2fft_pkg::dp_cmd_t                 cmd;
  logic [MAX_LOG2_SIZE-1:0]           waddr, raddr_a, raddr_b;
  logic [r2fft_pkg::TW_IDX_W-1:0]     tw_idx;

  // sequencing: load, permutation, butterfly stages, bin emission
  r2fft_ctrl #(
    .AW (MAX_LOG2_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bin_index_o (bin_index_o),
    .last_bin_o  (last_bin_o),
    .cmd_o       (cmd),
    .waddr_o     (waddr),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .tw_idx_o    (tw_idx)
  );

  // frame buffer and arithmetic; output data register holds through stalls
  r2fft_dp #(
    .AW (MAX_LOG2_SIZE),
    .TW (TWIDDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .waddr_i     (waddr),
    .raddr_a_i   (raddr_a),
    .raddr_b_i   (raddr_b),
    .tw_idx_i    (tw_idx),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o)
  );

endmodule

/* dv/radix2_complex_fft_top_test.sv */
// self-checking testbench for radix2_complex_fft_top: random bursts and stalls on both sides
// predicts each fft frame in fixed point; depends on r2fft_pkg and the rtl under src
`timescale 1ns / 100ps

module radix2_complex_fft_top_test;

  localparam int LATENCY_PAUSE = 80;   // idle cycles before a register write
  localparam int HOLDOFF_CYCLES = 400; // long receiver hold-off

  typedef struct {
    logic signed [r2fft_pkg::DATA_W-1:0] re;
    logic signed [r2fft_pkg::DATA_W-1:0] im;
    logic [r2fft_pkg::BIN_W-1:0]         idx;
    logic                                last;
  } bin_t;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  cfg_valid_i;
  logic                                  cfg_ready_o;
  logic [r2fft_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [r2fft_pkg::CFG_DATA_W-1:0]      cfg_data_i;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re_i;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic signed [r2fft_pkg::DATA_W-1:0]   out_re_o;
  logic signed [r2fft_pkg::DATA_W-1:0]   out_im_o;
  logic [r2fft_pkg::BIN_W-1:0]           bin_index_o;
  logic                                  last_bin_o;

  radix2_complex_fft_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .sample_re_i(sample_re_i), .sample_im_i(sample_im_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_re_o(out_re_o), .out_im_o(out_im_o),
    .bin_index_o(bin_index_o), .last_bin_o(last_bin_o)
  );

  // predictor state
  longint   fb_re [64];
  longint   fb_im [64];
  int       fill_count;
  int       size_reg;
  bit       inv_reg;
  bin_t     bins_pending [$];

  int       errors;
  int       items_sent;
  int       burst_left;
  bit       hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------- fixed-point predictor ----------------

  // add half, then floor shift
  function automatic longint round_sh(longint x, int s);
    if (s == 0) return x;
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip22(longint v);
    if (v > 2097151) return 2097151;
    if (v < -2097152) return -2097152;
    return v;
  endfunction

  // quarter-wave table narrowed to q1.15, saturated just below one
  function automatic longint sine_q15(int k);
    longint v;
    v = round_sh(longint'(r2fft_pkg::QUARTER_ROM[k]), r2fft_pkg::ROM_FRAC + 1 - 16);
    return (v > 32767) ? 32767 : v;
  endfunction

  function automatic int reverse_index(int v, int nbits);
    int r;
    r = 0;
    for (int i = 0; i < nbits; i++) if (v[i]) r |= 1 << (nbits - 1 - i);
    return r;
  endfunction

  task automatic run_fft(int lg, bit inv);
    int     n;
    int     r;
    int     e;
    int     m;
    int     h;
    longint t;
    longint c;
    longint sn;
    longint wi;
    longint tr;
    longint ti;
    longint ar;
    longint ai;
    longint br;
    longint bi;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = reverse_index(i, lg);
      if (r > i) begin
        t = fb_re[i]; fb_re[i] = fb_re[r]; fb_re[r] = t;
        t = fb_im[i]; fb_im[i] = fb_im[r]; fb_im[r] = t;
      end
    end
    for (int s = 1; s <= lg; s++) begin
      m = 1 << s;
      h = m >> 1;
      for (int k = 0; k < n; k += m) begin
        for (int j = 0; j < h; j++) begin
          e = (j << (6 - s)) & 31;
          if (e <= 16) begin
            sn = sine_q15(e);
            c  = sine_q15(16 - e);
          end else begin
            c  = -sine_q15(e - 16);
            sn = sine_q15(32 - e);
          end
          wi = inv ? sn : -sn;
          ar = fb_re[k+j];   ai = fb_im[k+j];
          br = fb_re[k+j+h]; bi = fb_im[k+j+h];
          tr = round_sh(c * br - wi * bi, 15);
          ti = round_sh(c * bi + wi * br, 15);
          fb_re[k+j]   = clip22(ar + tr);
          fb_im[k+j]   = clip22(ai + ti);
          fb_re[k+j+h] = clip22(ar - tr);
          fb_im[k+j+h] = clip22(ai - ti);
        end
      end
    end
    if (inv) begin
      for (int i = 0; i < n; i++) begin
        fb_re[i] = round_sh(fb_re[i], lg);
        fb_im[i] = round_sh(fb_im[i], lg);
      end
    end
  endtask

  // store one accepted sample; a completed frame queues its bins
  task automatic load_sample(logic signed [r2fft_pkg::SAMPLE_W-1:0] re,
                             logic signed [r2fft_pkg::SAMPLE_W-1:0] im);
    int   lg;
    int   n;
    bin_t b;
    lg = size_reg;
    if (lg < 1) lg = 1;
    if (lg > 6) lg = 6;
    n = 1 << lg;
    fill_count &= 63;
    fb_re[fill_count] = longint'(re);
    fb_im[fill_count] = longint'(im);
    if (fill_count + 1 < n) begin
      fill_count++;
    end else begin
      fill_count = 0;
      run_fft(lg, inv_reg);
      for (int i = 0; i < n; i++) begin
        b.re   = fb_re[i][r2fft_pkg::DATA_W-1:0];
        b.im   = fb_im[i][r2fft_pkg::DATA_W-1:0];
        b.idx  = i[r2fft_pkg::BIN_W-1:0];
        b.last = (i == n - 1);
        bins_pending.push_back(b);
      end
    end
  endtask

  // ---------------- drivers ----------------

  // one sample transfer; entered and left at a falling edge
  task automatic send_sample(logic signed [r2fft_pkg::SAMPLE_W-1:0] re,
                             logic signed [r2fft_pkg::SAMPLE_W-1:0] im);
    int g;
    if (burst_left == 0) begin
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    load_sample(re, im);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // wait until every expected bin is out and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    wait (bins_pending.size() == 0);
    repeat (LATENCY_PAUSE) @(negedge clk_i);
  endtask

  task automatic write_reg(r2fft_pkg::cfg_reg_e idx, logic [r2fft_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == r2fft_pkg::CFG_LOG2_SIZE) size_reg = data & 7;
    else if (idx == r2fft_pkg::CFG_INVERSE_MODE) inv_reg = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [r2fft_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return r2fft_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  // ---------------- receiver and checker ----------------

  initial begin
    int mode_cnt;
    int mode;
    out_stall_i = 1'b0;
    mode_cnt = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && out_valid_o) begin
        // long hold-off once bins are waiting, so the block backs up into its input
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if (mode_cnt == 0) begin
          mode = $urandom_range(0, 2);
          mode_cnt = $urandom_range(16, 96);
        end
        mode_cnt--;
        case (mode)
          0: out_stall_i <= 1'b0;                          // no stall stretch
          1: out_stall_i <= ($urandom_range(0, 3) == 0);  // light
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    bin_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bins_pending.size() == 0) begin
        $display("%0t: unexpected bin transfer re=%0d im=%0d idx=%0d", $realtime,
                 out_re_o, out_im_o, bin_index_o);
        errors++;
      end else begin
        want = bins_pending.pop_front();
        if (out_re_o !== want.re) begin
          $display("%0t: out_re expected %0d actual %0d", $realtime, want.re, out_re_o);
          errors++;
        end
        if (out_im_o !== want.im) begin
          $display("%0t: out_im expected %0d actual %0d", $realtime, want.im, out_im_o);
          errors++;
        end
        if (bin_index_o !== want.idx) begin
          $display("%0t: bin_index expected %0d actual %0d", $realtime, want.idx, bin_index_o);
          errors++;
        end
        if (last_bin_o !== want.last) begin
          $display("%0t: last_bin expected %0d actual %0d", $realtime, want.last, last_bin_o);
          errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------

  // reset settings (64 points, forward) with the receiver holding off
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 128; i++) send_sample(pick_sample(), pick_sample());
    wait_idle();
  endtask

  // two- and four-point frames at the field extremes, both directions
  task automatic test_extremes();
    write_reg(r2fft_pkg::CFG_LOG2_SIZE, 8'd1);
    write_reg(r2fft_pkg::CFG_INVERSE_MODE, 8'd0);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    wait_idle();
    write_reg(r2fft_pkg::CFG_LOG2_SIZE, 8'd2);
    write_reg(r2fft_pkg::CFG_INVERSE_MODE, 8'hff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'shffff, 16'sh0001);
    wait_idle();
  endtask

  // size zero acts as two points; index outside the register list is dropped
  task automatic test_size_and_index();
    write_reg(r2fft_pkg::CFG_LOG2_SIZE, 8'd0);
    write_reg(r2fft_pkg::CFG_INVERSE_MODE, 8'd0);
    write_reg(r2fft_pkg::cfg_reg_e'(4'd2), 8'h05);
    write_reg(r2fft_pkg::cfg_reg_e'(4'd15), 8'h01);
    send_sample(16'sh1234, 16'shedcb);
    send_sample(16'sh8000, 16'sh0000);
    wait_idle();
  endtask

  // shrink the frame while part of it is loaded
  task automatic test_shrink_mid_frame();
    write_reg(r2fft_pkg::CFG_LOG2_SIZE, 8'd3);
    for (int i = 0; i < 3; i++) send_sample(pick_sample(), pick_sample());
    wait_idle();
    write_reg(r2fft_pkg::CFG_LOG2_SIZE, 8'd1);
    send_sample(16'sh4000, 16'shc000);
    wait_idle();
  endtask

  // random frames, mostly small sizes, now and then the largest or an out-of-range size
  task automatic test_random_frames();
    int lg;
    int n;
    while (items_sent < 450) begin
      case ($urandom_range(0, 9))
        0: lg = 6;
        1: lg = 7;
        2: lg = 0;
        default: lg = $urandom_range(1, 4);
      endcase
      write_reg(r2fft_pkg::CFG_LOG2_SIZE, {5'($urandom_range(0, 31)), 3'(lg)});
      write_reg(r2fft_pkg::CFG_INVERSE_MODE,
                r2fft_pkg::CFG_DATA_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(r2fft_pkg::cfg_reg_e'(r2fft_pkg::CFG_IDX_W'($urandom_range(2, 15))),
                  r2fft_pkg::CFG_DATA_W'($urandom()));
      end
      n = 1 << ((lg < 1) ? 1 : (lg > 6) ? 6 : lg);
      for (int i = 0; i < n; i++) send_sample(pick_sample(), pick_sample());
      wait_idle();
    end
  endtask

  initial begin
    errors      = 0;
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    fill_count  = 0;
    size_reg    = r2fft_pkg::LOG2_RESET;
    inv_reg     = 1'b0;
    for (int i = 0; i < 64; i++) begin
      fb_re[i] = 0;
      fb_im[i] = 0;
    end
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_re_i = '0;
    sample_im_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_backpressure();
    test_extremes();
    test_size_and_index();
    test_shrink_mid_frame();
    test_random_frames();

    wait (bins_pending.size() == 0);
    repeat (LATENCY_PAUSE) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/r2fft_pkg.sv
src/r2fft_dp.sv
src/r2fft_ctrl.sv
src/radix2_complex_fft_top.sv
dv/radix2_complex_fft_top_test.sv
